// ===== rtl/core/swhsr_pkg.sv =====
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; every rtl/core file refers to this package by scoped names.
package swhsr_pkg;

    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned BITCNT_W   = 6;
    localparam int unsigned EDGE_W     = 7;
    localparam int unsigned RUN_W      = 8;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [EDGE_W-1:0]   MAX_EDGES   = 7'd85;
    localparam logic [BITCNT_W-1:0] FRAME_BITS  = 6'd40;
    localparam logic [RUN_W-1:0]    RUN_MAX     = 8'd255;

    localparam logic [15:0] RST_PREHIGH   = 16'd10000;
    localparam logic [15:0] RST_START_LOW = 16'd18000;
    localparam logic [7:0]  RST_RELEASE   = 8'd40;
    localparam logic [7:0]  RST_ONE_THR   = 8'd16;
    localparam logic [7:0]  RST_TIMEOUT   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_PREHIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREHIGH  = 3'd1,
        PH_STARTLOW = 3'd2,
        PH_RELEASE  = 3'd3,
        PH_MEASURE  = 3'd4
    } t_phase;

    typedef struct packed {
        logic command;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic                drive_enable;
        logic                drive_value;
        logic                busy_res;
        logic                done_res;
        logic                data_ok;
        logic [15:0]         humidity_tenths;
        logic signed [15:0]  temperature_tenths;
        logic [BITCNT_W-1:0] bits_received;
    } t_out_item;

    typedef struct packed {
        logic               data_ok;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } t_decode;

endpackage

// ===== rtl/core/swhsr_frame_decode.sv =====
// Checksum check and unit conversion of a captured 40-bit sensor frame.
// Depends on swhsr_pkg.
module swhsr_frame_decode (
    input  logic [swhsr_pkg::FRAME_W-1:0] i_frame,
    input  logic                          i_complete,
    output swhsr_pkg::t_decode            o_decode
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] mag;

    assign b0  = i_frame[39:32];
    assign b1  = i_frame[31:24];
    assign b2  = i_frame[23:16];
    assign b3  = i_frame[15:8];
    assign b4  = i_frame[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign mag = {1'b0, b2[6:0], b3};

    always_comb begin
        o_decode = '0;
        if (i_complete && (sum == b4)) begin
            o_decode.data_ok         = 1'b1;
            o_decode.humidity_tenths = {b0, b1};
            if (b2[7]) begin
                o_decode.temperature_tenths = 16'd0 - mag;
            end else begin
                o_decode.temperature_tenths = mag;
            end
        end
    end

endmodule

// ===== rtl/core/single_wire_humidity_sensor_reader_core.sv =====
// Top level of the single-wire humidity sensor reader: phase sequencer,
// run timing, bit capture and a two-entry result buffer.
// Depends on swhsr_pkg and swhsr_frame_decode.
//
//  channel | direction | signals                                  | handshake
//  --------+-----------+------------------------------------------+----------
//  in      | input     | i_in_data (t_in_item)                    | valid/ready
//  out     | output    | o_out_data (t_out_item)                  | valid/ready
//  cfg     | input     | i_cfg_index, i_cfg_wdata                 | write enable
//
// One item per cycle while the input is ready; each accepted item updates
// the state and registers its result in the output or skid register.
// A skid register holds a second result, so the input stalls only when both
// the output and skid registers are full.
// Synchronous active-low reset returns to idle, control regs at defaults.
module single_wire_humidity_sensor_reader_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  swhsr_pkg::t_in_item                     i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output swhsr_pkg::t_out_item                    o_out_data,
    input  logic                                    i_cfg_wr_en,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    logic [15:0] r_prehigh, r_start_low;
    logic [7:0]  r_release, r_one_thr, r_timeout;

    swhsr_pkg::t_phase                   r_phase, n_phase;
    logic [swhsr_pkg::TIMER_W-1:0]       r_timer, n_timer;
    logic                                r_last_level, n_last_level;
    logic [swhsr_pkg::RUN_W-1:0]         r_run, n_run;
    logic [swhsr_pkg::EDGE_W-1:0]        r_edge_idx, n_edge_idx;
    logic [swhsr_pkg::BITCNT_W-1:0]      r_bit_count, n_bit_count;
    logic [swhsr_pkg::FRAME_W-1:0]       r_frame, n_frame;

    logic                                r_out_vld, r_skid_vld;
    swhsr_pkg::t_out_item                r_out, r_skid;

    logic                                accept, take, done;
    swhsr_pkg::t_phase                   from_prehigh, from_startlow, from_release;
    swhsr_pkg::t_phase                   step_next;
    logic [15:0]                         drive_len, timer_inc;
    logic [swhsr_pkg::RUN_W-1:0]         run_inc;
    logic [swhsr_pkg::EDGE_W-1:0]        edge_inc;
    swhsr_pkg::t_decode                  dec;
    swhsr_pkg::t_out_item                result;

    assign o_in_ready  = !r_skid_vld;
    assign accept      = i_in_valid && o_in_ready;
    assign take        = r_out_vld && i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prehigh   <= swhsr_pkg::RST_PREHIGH;
            r_start_low <= swhsr_pkg::RST_START_LOW;
            r_release   <= swhsr_pkg::RST_RELEASE;
            r_one_thr   <= swhsr_pkg::RST_ONE_THR;
            r_timeout   <= swhsr_pkg::RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                swhsr_pkg::CFG_PREHIGH:   r_prehigh   <= i_cfg_wdata;
                swhsr_pkg::CFG_START_LOW: r_start_low <= i_cfg_wdata;
                swhsr_pkg::CFG_RELEASE:   r_release   <= i_cfg_wdata[7:0];
                swhsr_pkg::CFG_ONE_THR:   r_one_thr   <= i_cfg_wdata[7:0];
                swhsr_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // skip drive phases whose length is zero
    assign from_release  = (r_release != 8'd0) ? swhsr_pkg::PH_RELEASE
                                               : swhsr_pkg::PH_MEASURE;
    assign from_startlow = (r_start_low != 16'd0) ? swhsr_pkg::PH_STARTLOW : from_release;
    assign from_prehigh  = (r_prehigh != 16'd0) ? swhsr_pkg::PH_PREHIGH : from_startlow;

    always_comb begin
        unique case (r_phase)
            swhsr_pkg::PH_PREHIGH: begin
                drive_len = r_prehigh;
                step_next = from_startlow;
            end
            swhsr_pkg::PH_STARTLOW: begin
                drive_len = r_start_low;
                step_next = from_release;
            end
            default: begin
                drive_len = {8'd0, r_release};
                step_next = swhsr_pkg::PH_MEASURE;
            end
        endcase
    end

    assign timer_inc = r_timer + 16'd1;
    assign run_inc   = (r_run < swhsr_pkg::RUN_MAX) ? r_run + 8'd1 : r_run;
    assign edge_inc  = r_edge_idx + 7'd1;

    always_comb begin
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_last_level = r_last_level;
        n_run        = r_run;
        n_edge_idx   = r_edge_idx;
        n_bit_count  = r_bit_count;
        n_frame      = r_frame;
        done         = 1'b0;
        priority if (i_in_data.command) begin
            n_frame      = '0;
            n_bit_count  = '0;
            n_edge_idx   = '0;
            n_run        = '0;
            n_last_level = 1'b1;
            n_timer      = '0;
            n_phase      = from_prehigh;
        end else if (r_phase == swhsr_pkg::PH_PREHIGH || r_phase == swhsr_pkg::PH_STARTLOW
                     || r_phase == swhsr_pkg::PH_RELEASE) begin
            n_timer = timer_inc;
            if (timer_inc >= drive_len) begin
                n_phase = step_next;
                n_timer = '0;
                if (step_next == swhsr_pkg::PH_MEASURE) begin
                    n_last_level = 1'b1;
                    n_run        = '0;
                end
            end
        end else if (r_phase == swhsr_pkg::PH_MEASURE) begin
            if (i_in_data.line_level == r_last_level) begin
                n_run = run_inc;
                done  = (run_inc >= r_timeout);
            end else begin
                if (r_edge_idx >= 7'd4 && !r_edge_idx[0]
                    && r_bit_count < swhsr_pkg::FRAME_BITS) begin
                    n_frame     = {r_frame[swhsr_pkg::FRAME_W-2:0], (r_run > r_one_thr)};
                    n_bit_count = r_bit_count + 6'd1;
                end
                n_last_level = i_in_data.line_level;
                n_run        = '0;
                n_edge_idx   = edge_inc;
                done         = (edge_inc >= swhsr_pkg::MAX_EDGES);
            end
            if (done) begin
                n_phase = swhsr_pkg::PH_IDLE;
                n_timer = '0;
            end
        end else begin
            n_phase = swhsr_pkg::PH_IDLE;
        end
    end

    swhsr_frame_decode u_decode (
        .i_frame    (n_frame),
        .i_complete ((n_phase == swhsr_pkg::PH_IDLE)
                     && (n_bit_count >= swhsr_pkg::FRAME_BITS)),
        .o_decode   (dec)
    );

    always_comb begin
        result                    = '0;
        result.drive_enable       = (n_phase == swhsr_pkg::PH_PREHIGH)
                                    || (n_phase == swhsr_pkg::PH_STARTLOW)
                                    || (n_phase == swhsr_pkg::PH_RELEASE);
        result.drive_value        = (n_phase == swhsr_pkg::PH_PREHIGH)
                                    || (n_phase == swhsr_pkg::PH_RELEASE);
        result.busy_res           = (n_phase != swhsr_pkg::PH_IDLE);
        result.done_res           = done;
        result.data_ok            = dec.data_ok;
        result.humidity_tenths    = dec.humidity_tenths;
        result.temperature_tenths = dec.temperature_tenths;
        result.bits_received      = n_bit_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= swhsr_pkg::PH_IDLE;
            r_timer      <= '0;
            r_last_level <= 1'b1;
            r_run        <= '0;
            r_edge_idx   <= '0;
            r_bit_count  <= '0;
            r_frame      <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_timer      <= n_timer;
            r_last_level <= n_last_level;
            r_run        <= n_run;
            r_edge_idx   <= n_edge_idx;
            r_bit_count  <= n_bit_count;
            r_frame      <= n_frame;
        end
    end

    // result buffer: output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !take) begin
            if (accept) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !take) begin
            if (accept) begin
                r_skid <= result;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else if (accept) begin
            r_out <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    a_bit_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= swhsr_pkg::FRAME_BITS)
        else $error("bit count beyond frame length");

    a_ok_frame_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.data_ok) |->
            (r_out.bits_received == swhsr_pkg::FRAME_BITS) && !r_out.busy_res)
        else $error("data_ok without a full frame on an idle block");

    a_done_ends_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && done) |=> (r_phase == swhsr_pkg::PH_IDLE))
        else $error("read end did not return to idle");

endmodule
